/* hw/rtl/lcabl_pkg.sv */
`default_nettype none

package lcabl_pkg;

  localparam int NODE_W = 16;
  localparam int DEPTH_W = 16;
  localparam int DIST_W = 17;
  localparam int LVL_FW = 5;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [LVL_FW-1:0]  lvl_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Request to the ancestor table: one write and two reads at a shared level.
  typedef struct packed {
    logic  we;
    node_t wnode;
    lvl_t  wlvl;
    node_t wdata;
    logic  re;
    node_t rnode0;
    node_t rnode1;
    lvl_t  rlvl;
  } tbl_req_t;

endpackage

`default_nettype wire

/* hw/rtl/lcabl_if.sv */
`default_nettype none

interface lcabl_req_if;
  import lcabl_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  node_t node_a;
  node_t node_b;

  modport source (output valid, action, node_a, node_b, input ready);
  modport sink (input valid, action, node_a, node_b, output ready);
endinterface

interface lcabl_rsp_if;
  import lcabl_pkg::*;

  logic  valid;
  logic  ready;
  node_t ancestor;
  dist_t distance;

  modport source (output valid, ancestor, distance, input ready);
  modport sink (input valid, ancestor, distance, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lcabl_table.sv */
`default_nettype none

module lcabl_table #(
  parameter int NODES = 65536,
  parameter int LEVELS = 16
) (
  input  logic               clk,
  input  lcabl_pkg::tbl_req_t tq,
  output lcabl_pkg::node_t    rd0,
  output lcabl_pkg::node_t    rd1
);
  import lcabl_pkg::*;

  localparam int IDX_W = $clog2(NODES);
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADDR_W = IDX_W + LVL_W;
  localparam int TDEPTH = NODES * (2 ** LVL_W);

  node_t mem [TDEPTH];

  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr0;
  logic [ADDR_W-1:0] raddr1;
  node_t raw0;
  node_t raw1;
  logic  zero0;
  logic  zero1;

  assign waddr  = {IDX_W'(tq.wnode), LVL_W'(tq.wlvl)};
  assign raddr0 = {IDX_W'(tq.rnode0), LVL_W'(tq.rlvl)};
  assign raddr1 = {IDX_W'(tq.rnode1), LVL_W'(tq.rlvl)};

  // Write-first: a read of the row being written sees the new word.
  always_ff @(posedge clk) begin
    if (tq.we) begin
      mem[waddr] <= tq.wdata;
    end
    if (tq.re) begin
      raw0  <= (tq.we && (waddr == raddr0)) ? tq.wdata : mem[raddr0];
      raw1  <= (tq.we && (waddr == raddr1)) ? tq.wdata : mem[raddr1];
      zero0 <= (tq.rnode0 == '0);
      zero1 <= (tq.rnode1 == '0);
    end
  end

  // Sentinel row reads as zero and is never stored.
  assign rd0 = zero0 ? '0 : raw0;
  assign rd1 = zero1 ? '0 : raw1;

endmodule

`default_nettype wire

/* hw/rtl/lca_binary_lifting.sv */
`default_nettype none

// Lowest common ancestor by binary lifting over a stored tree.
// Channels: req carries action, node_a, node_b; rsp carries ancestor and
// distance. A word moves when valid and ready are both high at a clock edge.
// A load word (action 0) stores node_a under parent node_b; load parents
// before children. It gives no rsp word. A query word (action 1) gives one
// rsp word: the common ancestor and the edge count between the two nodes.
// One word is processed at a time; req.ready is high only while idle.
// Loads and queries each run a chain of dependent reads of the ancestor
// table through its registered read port. With NODES not a power of two
// and below 65536, node numbers are first reduced.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// pending rsp word. The stores are not cleared; node 0 always reads as zero.
// When the receiver stalls, the finished rsp word is held in its register
// and the next req word may still be taken; a second result then waits
// until the first one has gone.
module lca_binary_lifting #(
  parameter int NODES = 65536,
  parameter int LEVELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  lcabl_req_if.sink   req,
  lcabl_rsp_if.source rsp
);
  import lcabl_pkg::*;

  localparam int IDX_W = $clog2(NODES);
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);
  localparam bit POW2 = ((NODES & (NODES - 1)) == 0);
  localparam bit NEED_RED = !POW2 && (NODES < 65536);
  localparam node_t NODE_MASK = (POW2 && (NODES < 65536)) ?
                                NODE_W'(NODES - 1) : '1;
  localparam logic [31:0] NODES32 = 32'(NODES);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RED   = 12'b000000000010,
    S_START = 12'b000000000100,
    S_LDEP  = 12'b000000001000,
    S_LFILL = 12'b000000010000,
    S_QDEP  = 12'b000000100000,
    S_LIFT  = 12'b000001000000,
    S_LWAIT = 12'b000010000000,
    S_CMP   = 12'b000100000000,
    S_SWAIT = 12'b001000000000,
    S_PAR   = 12'b010000000000,
    S_FDEP  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   act, act_next;
  node_t  u, u_next;
  node_t  v, v_next;
  depth_t da, da_next;
  depth_t db, db_next;
  logic [LEVELS-1:0] diff, diff_next;
  logic [LVL_W-1:0]  lvl, lvl_next;
  logic [3:0]        red_k, red_k_next;
  logic [31:0]       red_cmp;

  logic  ovalid;
  logic  out_load;
  node_t anc_q;
  dist_t dist_q;
  dist_t dist_new;

  // Ancestor table
  tbl_req_t tq;
  node_t    trd0;
  node_t    trd1;
  node_t    nu;
  node_t    nv;

  lcabl_table #(.NODES(NODES), .LEVELS(LEVELS)) u_table (
    .clk (clk),
    .tq  (tq),
    .rd0 (trd0),
    .rd1 (trd1)
  );

  // Depth store: two read ports, one write port, entry 0 reads zero.
  depth_t depth_mem [NODES];
  logic   dwe;
  depth_t dwdata;
  logic   dre;
  node_t  dnode0;
  node_t  dnode1;
  depth_t draw0;
  depth_t draw1;
  logic   dzero0;
  logic   dzero1;
  depth_t drd0;
  depth_t drd1;

  always_ff @(posedge clk) begin
    if (dwe) begin
      depth_mem[IDX_W'(u)] <= dwdata;
    end
    if (dre) begin
      draw0  <= depth_mem[IDX_W'(dnode0)];
      draw1  <= depth_mem[IDX_W'(dnode1)];
      dzero0 <= (dnode0 == '0);
      dzero1 <= (dnode1 == '0);
    end
  end

  assign drd0 = dzero0 ? '0 : draw0;
  assign drd1 = dzero1 ? '0 : draw1;

  assign red_cmp = NODES32 << red_k;

  // Lock-step climb: advance both nodes only where their ancestors differ.
  assign nu = (trd0 != trd1) ? trd0 : u;
  assign nv = (trd0 != trd1) ? trd1 : v;

  // Each depth difference saturates at zero.
  always_comb begin
    depth_t sa;
    depth_t sb;
    sa = (da > drd0) ? depth_t'(da - drd0) : '0;
    sb = (db > drd0) ? depth_t'(db - drd0) : '0;
    dist_new = {1'b0, sa} + {1'b0, sb};
  end

  assign req.ready = (state == S_IDLE);
  assign out_load  = (state == S_FDEP) && (!ovalid || rsp.ready);

  always_comb begin
    state_next = state;
    act_next   = act;
    u_next     = u;
    v_next     = v;
    da_next    = da;
    db_next    = db;
    diff_next  = diff;
    lvl_next   = lvl;
    red_k_next = red_k;
    tq         = '0;
    dwe        = 1'b0;
    dwdata     = '0;
    dre        = 1'b0;
    dnode0     = u;
    dnode1     = v;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          act_next   = req.action;
          u_next     = req.node_a & NODE_MASK;
          v_next     = req.node_b & NODE_MASK;
          red_k_next = '1;
          state_next = NEED_RED ? S_RED : S_START;
        end
      end

      S_RED: begin
        // Restoring reduction: subtract NODES << k where it fits.
        if ({16'b0, u} >= red_cmp) begin
          u_next = u - red_cmp[15:0];
        end
        if ({16'b0, v} >= red_cmp) begin
          v_next = v - red_cmp[15:0];
        end
        red_k_next = red_k - 4'd1;
        if (red_k == '0) begin
          state_next = S_START;
        end
      end

      S_START: begin
        if (act == ACT_LOAD) begin
          if (u == '0) begin
            // Drop loads of the sentinel.
            state_next = S_IDLE;
          end else begin
            tq.we      = 1'b1;
            tq.wnode   = u;
            tq.wlvl    = '0;
            tq.wdata   = v;
            tq.re      = 1'b1;
            tq.rnode0  = v;
            tq.rnode1  = v;
            tq.rlvl    = '0;
            dre        = 1'b1;
            lvl_next   = LVL_W'(1);
            state_next = S_LDEP;
          end
        end else begin
          dre        = 1'b1;
          state_next = S_QDEP;
        end
      end

      S_LDEP: begin
        dwe    = 1'b1;
        dwdata = (drd1 == '1) ? drd1 : drd1 + depth_t'(1);
        state_next = (LEVELS == 1) ? S_IDLE : S_LFILL;
      end

      S_LFILL: begin
        tq.we    = 1'b1;
        tq.wnode = u;
        tq.wlvl  = lvl_t'(lvl);
        tq.wdata = trd0;
        if (lvl == LVL_LAST) begin
          state_next = S_IDLE;
        end else begin
          tq.re     = 1'b1;
          tq.rnode0 = trd0;
          tq.rnode1 = trd0;
          tq.rlvl   = lvl_t'(lvl);
          lvl_next  = lvl + LVL_W'(1);
        end
      end

      S_QDEP: begin
        da_next = drd0;
        db_next = drd1;
        if (drd0 < drd1) begin
          u_next    = v;
          v_next    = u;
          diff_next = LEVELS'(depth_t'(drd1 - drd0));
        end else begin
          diff_next = LEVELS'(depth_t'(drd0 - drd1));
        end
        lvl_next   = '0;
        state_next = S_LIFT;
      end

      S_LIFT: begin
        if (diff[lvl]) begin
          tq.re      = 1'b1;
          tq.rnode0  = u;
          tq.rnode1  = u;
          tq.rlvl    = lvl_t'(lvl);
          state_next = S_LWAIT;
        end else if (lvl == LVL_LAST) begin
          state_next = S_CMP;
        end else begin
          lvl_next = lvl + LVL_W'(1);
        end
      end

      S_LWAIT: begin
        u_next = trd0;
        if (lvl == LVL_LAST) begin
          state_next = S_CMP;
        end else begin
          lvl_next   = lvl + LVL_W'(1);
          state_next = S_LIFT;
        end
      end

      S_CMP: begin
        if (u == v) begin
          dre        = 1'b1;
          dnode0     = u;
          state_next = S_FDEP;
        end else begin
          tq.re      = 1'b1;
          tq.rnode0  = u;
          tq.rnode1  = v;
          tq.rlvl    = lvl_t'(LVL_LAST);
          lvl_next   = LVL_LAST;
          state_next = S_SWAIT;
        end
      end

      S_SWAIT: begin
        u_next    = nu;
        v_next    = nv;
        tq.re     = 1'b1;
        tq.rnode0 = nu;
        tq.rnode1 = nv;
        if (lvl == '0) begin
          tq.rlvl    = '0;
          state_next = S_PAR;
        end else begin
          tq.rlvl  = lvl_t'(lvl - LVL_W'(1));
          lvl_next = lvl - LVL_W'(1);
        end
      end

      S_PAR: begin
        u_next     = trd0;
        dre        = 1'b1;
        dnode0     = trd0;
        state_next = S_FDEP;
      end

      S_FDEP: begin
        // Hold until the rsp register is free.
        if (!ovalid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    act   <= act_next;
    u     <= u_next;
    v     <= v_next;
    da    <= da_next;
    db    <= db_next;
    diff  <= diff_next;
    lvl   <= lvl_next;
    red_k <= red_k_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_load) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      anc_q  <= u;
      dist_q <= dist_new;
    end
  end

  assign rsp.valid    = ovalid;
  assign rsp.ancestor = anc_q;
  assign rsp.distance = dist_q;

endmodule

`default_nettype wire
